FILE: rtl/pidc_pkg.sv
package pidc_pkg;

    // field widths
    localparam int IN_W       = 16;
    localparam int S_DATA_W   = 3 * IN_W;
    localparam int OUT_W      = 8;
    localparam int ERR_W      = IN_W + 1;
    localparam int SUM_W      = 32;

    // shared multiplier and accumulator
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 50;
    localparam int DRV_FULL_W = ACC_W - 8;

    // derivative divider
    localparam int DIV_N_W    = 26;
    localparam int DIV_D_W    = 16;
    localparam int DIV_CNT_W  = 5;
    localparam int DERIV_W    = DIV_N_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // derivative scale, ms to seconds
    localparam logic signed [MUL_B_W-1:0] DERIV_SCALE = 16'sd1000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP     = 3'd0,
        CFG_KI     = 3'd1,
        CFG_KD     = 3'd2,
        CFG_MARGIN = 3'd3,
        CFG_MAX    = 3'd4,
        CFG_MIN    = 3'd5
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCALE,
        S_PTERM,
        S_ITERM,
        S_DWAIT,
        S_DACC,
        S_CLAMP
    } t_state;

    // multiply-accumulate command
    typedef struct packed {
        logic mul;
        logic load;
        logic add;
    } t_mac_op;

endpackage

FILE: rtl/pid_drive_controller.sv
// PID drive controller: one input item {target_pos, sensor_value, elapsed_ms}
// gives one 8-bit drive item. A changed target clears the integral; the
// integral adds the error only while |error| < error_margin, else it is
// cleared, and saturates at 32 bits. The derivative is taken on the
// measurement, (sensor - last sensor) * 1000 / elapsed_ms truncated toward
// zero, and is zero when elapsed_ms is zero. Drive = floor((P+I+D)/256) with
// signed Q8.8 gains, limited to max_drive and then raised to min_drive.
// One multiplier and a 26-step restoring divider are shared under a small
// sequencer, so o_s_tready is high only between items: an item passes
// through prep, scale, P, I, a wait on the divider (one quotient bit per
// cycle, run only when elapsed_ms is nonzero), D and clamp, and the last
// step holds while a drive item is still untaken.
// Configuration writes are always taken (o_cfg_ready high) and must only
// be made while the controller is idle; indexes 6 and 7 are ignored.
module pid_drive_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [pidc_pkg::S_DATA_W-1:0]        i_s_tdata,   // target_pos, sensor_value, elapsed_ms
    // result item
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [pidc_pkg::OUT_W-1:0]           o_m_tdata,   // drive
    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pidc_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic signed [IN_W-1:0]   r_kp, r_ki, r_kd;
    logic [IN_W-1:0]          r_margin;
    logic signed [OUT_W-1:0]  r_max, r_min;

    // controller state
    logic signed [IN_W-1:0]   r_last_target, r_last_sensor;
    logic signed [SUM_W-1:0]  r_error_sum;

    // current item
    logic signed [IN_W-1:0]   r_target, r_sensor;
    logic [IN_W-1:0]          r_elapsed;
    logic signed [ERR_W-1:0]  r_err;
    logic                     r_dneg;

    // result register
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_drive;

    // datapath
    logic signed [ERR_W-1:0]      err_now, dsens;
    logic [ERR_W-1:0]             err_mag;
    logic                         in_window;
    logic signed [SUM_W-1:0]      sum_base, sum_sat, sum_next;
    logic signed [SUM_W:0]        sum_try;
    logic [DIV_N_W-1:0]           dmag, quotient;
    logic signed [DERIV_W-1:0]    deriv_q, deriv;
    logic signed [DRV_FULL_W-1:0] drv_full, max_ext, min_ext, drv_hi, drv_lo;
    logic                         out_free;

    // sequencer outputs
    logic                         s_ready, div_start, load_out, div_busy;
    t_mac_op                      mac_op;
    logic signed [MUL_A_W-1:0]    mac_a;
    logic signed [MUL_B_W-1:0]    mac_b;
    logic signed [PROD_W-1:0]     prod;
    logic signed [ACC_W-1:0]      acc;

    // error and integral window
    assign err_now   = ERR_W'(r_target) - ERR_W'(r_sensor);
    assign err_mag   = err_now[ERR_W-1] ? ERR_W'(-err_now) : ERR_W'(err_now);
    assign in_window = err_mag < {1'b0, r_margin};

    // integral: clear on new target, saturating add inside the window, clear outside it
    assign sum_base = (r_target != r_last_target) ? '0 : r_error_sum;
    assign sum_try  = (SUM_W+1)'(sum_base) + (SUM_W+1)'(err_now);
    assign sum_sat  = (sum_try[SUM_W] != sum_try[SUM_W-1])
                    ? (sum_try[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}})
                    : sum_try[SUM_W-1:0];
    assign sum_next = in_window ? sum_sat : '0;

    // derivative on measurement
    assign dsens   = ERR_W'(r_sensor) - ERR_W'(r_last_sensor);
    assign dmag    = prod[PROD_W-1] ? DIV_N_W'(-prod) : DIV_N_W'(prod);
    assign deriv_q = DERIV_W'({1'b0, quotient});
    assign deriv   = (r_elapsed == '0) ? '0 : (r_dneg ? -deriv_q : deriv_q);

    // floor divide by 256 and clamp
    assign drv_full = signed'(acc[ACC_W-1:8]);
    assign max_ext  = DRV_FULL_W'(r_max);
    assign min_ext  = DRV_FULL_W'(r_min);
    assign drv_hi   = (drv_full > max_ext) ? max_ext : drv_full;
    assign drv_lo   = (drv_hi < min_ext) ? min_ext : drv_hi;

    assign out_free = !r_out_valid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = S_PREP;
            S_PREP:  n_state = S_SCALE;
            S_SCALE: n_state = S_PTERM;
            S_PTERM: n_state = S_ITERM;
            S_ITERM: n_state = S_DWAIT;
            S_DWAIT: if (!div_busy) n_state = S_DACC;
            S_DACC:  n_state = S_CLAMP;
            S_CLAMP: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        mac_op    = '0;
        mac_a     = '0;
        mac_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_PREP: begin
                mac_op.mul = 1'b1;
                mac_a      = MUL_A_W'(dsens);
                mac_b      = DERIV_SCALE;
            end
            S_SCALE: begin
                div_start  = (r_elapsed != '0);
                mac_op.mul = 1'b1;
                mac_a      = MUL_A_W'(r_err);
                mac_b      = r_kp;
            end
            S_PTERM: begin
                mac_op.load = 1'b1;
                mac_op.mul  = 1'b1;
                mac_a       = r_error_sum;
                mac_b       = r_ki;
            end
            S_ITERM: begin
                mac_op.add = 1'b1;
            end
            S_DWAIT: begin
                mac_op.mul = !div_busy;
                mac_a      = MUL_A_W'(deriv);
                mac_b      = r_kd;
            end
            S_DACC: begin
                mac_op.add = 1'b1;
            end
            S_CLAMP: begin
                load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_kp          <= '0;
            r_ki          <= '0;
            r_kd          <= '0;
            r_margin      <= '0;
            r_max         <= 8'sd127;
            r_min         <= -8'sd127;
            r_last_target <= '0;
            r_last_sensor <= '0;
            r_error_sum   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_KP:     r_kp     <= signed'(i_cfg_data);
                    CFG_KI:     r_ki     <= signed'(i_cfg_data);
                    CFG_KD:     r_kd     <= signed'(i_cfg_data);
                    CFG_MARGIN: r_margin <= i_cfg_data;
                    CFG_MAX:    r_max    <= signed'(i_cfg_data[OUT_W-1:0]);
                    CFG_MIN:    r_min    <= signed'(i_cfg_data[OUT_W-1:0]);
                    default:    ;
                endcase
            end
            // step state update
            if (r_state == S_PREP) begin
                r_error_sum   <= sum_next;
                r_last_target <= r_target;
                r_last_sensor <= r_sensor;
            end
            // result handshake
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_target  <= signed'(i_s_tdata[IN_W-1:0]);
            r_sensor  <= signed'(i_s_tdata[2*IN_W-1:IN_W]);
            r_elapsed <= i_s_tdata[3*IN_W-1:2*IN_W];
        end
        if (r_state == S_PREP) begin
            r_err <= err_now;
        end
        if (r_state == S_SCALE) begin
            r_dneg <= prod[PROD_W-1];
        end
        if (load_out) begin
            r_drive <= drv_lo[OUT_W-1:0];
        end
    end

    // shared multiplier
    pidc_mac u_mac (
        .i_clk  (i_clk),
        .i_op   (mac_op),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (prod),
        .o_acc  (acc)
    );

    // derivative divider
    pidc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dmag),
        .i_divisor  (r_elapsed),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign o_s_tready  = s_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_drive;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: rtl/pidc_mac.sv
module pidc_mac (
    input  logic                                    i_clk,
    input  pidc_pkg::t_mac_op                       i_op,
    input  logic signed [pidc_pkg::MUL_A_W-1:0]     i_a,
    input  logic signed [pidc_pkg::MUL_B_W-1:0]     i_b,
    output logic signed [pidc_pkg::PROD_W-1:0]      o_prod,
    output logic signed [pidc_pkg::ACC_W-1:0]       o_acc
);
    import pidc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    // registered product, sign extended into the accumulator
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_op.mul) begin
            r_prod <= i_a * i_b;
        end
        if (i_op.load) begin
            r_acc <= prod_ext;
        end else if (i_op.add) begin
            r_acc <= r_acc + prod_ext;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

FILE: rtl/pidc_div.sv
module pidc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pidc_pkg::DIV_N_W-1:0]     i_dividend,
    input  logic [pidc_pkg::DIV_D_W-1:0]     i_divisor,
    output logic                             o_busy,
    output logic [pidc_pkg::DIV_N_W-1:0]     o_quotient
);
    import pidc_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_dvs;

    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, try to subtract
    assign trial = {r_rem, r_quo[DIV_N_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/pidc_checker.sv
module pidc_props (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [pidc_pkg::OUT_W-1:0]       o_m_tdata,
    input logic                             o_cfg_ready
);
    import pidc_pkg::*;

    // a waiting drive item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("drive item dropped while stalled");

    // a waiting drive item keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("drive changed while stalled");

    // the input stays closed just after an item is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready ##1 !o_s_tready)
        else $error("input reopened too early");

    // reset empties the result register and the config port stays open
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_cfg_ready)
        else $error("result valid after reset");

endmodule

bind pid_drive_controller pidc_props u_pidc_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_cfg_ready (o_cfg_ready)
);
